>>> rtl/fca_pkg.sv
`timescale 1ns / 1ps

package fca_pkg;

   // Default geometry
   localparam int ARENA_BYTES_DEF  = 4096;
   localparam int HEADER_BYTES_DEF = 32;
   localparam int MAX_BLOCKS_DEF   = 128;

   // Fixed field widths
   localparam int SIZE_IN_W   = 12;
   localparam int VAL_W       = 12;
   localparam int NEED_W      = 13;
   localparam int PAD_W       = 3;
   localparam int DOFF_W      = 12;
   localparam int BID_W       = 8;
   localparam int CNT_W       = 32;
   localparam int STRAT_W     = 2;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 88;

   // Fit strategy codes (anything else is first fit)
   localparam logic [STRAT_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [STRAT_W-1:0] FIT_WORST = 2'd2;

   typedef enum logic [1:0] {
      REQ_ALLOC       = 2'd0,
      REQ_FREE_OFF    = 2'd1,
      REQ_FREE_ID     = 2'd2,
      REQ_FREE_ID_OFF = 2'd3
   } fca_kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NO_FIT       = 3'd1,
      ST_BAD_ADDR     = 3'd2,
      ST_ALREADY_FREE = 3'd3,
      ST_NO_ID        = 3'd4
   } fca_status_type;

   // Block table write enables: main record and back link
   typedef struct packed {
      logic main;
      logic prev;
   } fca_wmask_type;

endpackage

>>> rtl/fit_allocator_with_coalescing_unit.sv
`timescale 1ns / 1ps

// Channel   Ports            Dir  tdata (low bit up)                 tuser
// req       req_t*           in   req_size[11:0], req_value[23:12]   req_type[1:0]
// rsp       rsp_t*           out  data_offset[11:0], block_id[19:12],
//                                 alloc_requests[51:20],
//                                 alloc_successes[83:52], zero pad   status[2:0]
// csr       csr_wr_*         in   fit_strategy[1:0]                  -
//
// One request at a time. A request walks the block chain in the table memory,
// one entry per cycle. An allocate then scans the chain/id bitmaps and writes
// up to three entries; a free reads both neighbors and writes up to three
// entries. Reset is synchronous; no clearing pass, the head entry reads as its
// reset record until written. The result sits in an output register, so a
// stalled rsp side holds only the following request's final step.

module fit_allocator_with_coalescing_unit #(
   parameter int ARENA_BYTES  = fca_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = fca_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = fca_pkg::MAX_BLOCKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: size, value
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fca_pkg::REQ_DATA_W-1:0]    req_tdata,
   // request kind
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // offset, id, alloc request count, alloc success count, pad
   output logic [fca_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [2:0]                        rsp_tuser,
   input  logic                              csr_wr_en,
   input  logic [fca_pkg::STRAT_W-1:0]       csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int LNK_W = $clog2(MAX_BLOCKS + 1);
   localparam int SZ_W  = $clog2(ARENA_BYTES) + 1;
   localparam int OWN_W = $clog2(MAX_BLOCKS + 2);
   localparam int CW    = (SZ_W > 13) ? SZ_W + 1 : 14;
   localparam int PAD_W = fca_pkg::PAD_W;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_WALK   = 14'b00000000000010,
      S_POST   = 14'b00000000000100,
      S_SCAN   = 14'b00000000001000,
      S_A_WR_S = 14'b00000000010000,
      S_A_WR_C = 14'b00000000100000,
      S_A_WR_N = 14'b00000001000000,
      S_F_RDN  = 14'b00000010000000,
      S_F_RDP  = 14'b00000100000000,
      S_F_GOTP = 14'b00001000000000,
      S_F_WR_C = 14'b00010000000000,
      S_F_WR_X = 14'b00100000000000,
      S_F_WR_P = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [fca_pkg::STRAT_W-1:0]     strat_ff;
   fca_pkg::fca_kind_type           kind_ff;
   logic [fca_pkg::SIZE_IN_W-1:0]   size_ff;
   logic [fca_pkg::VAL_W-1:0]       val_ff;
   logic [fca_pkg::NEED_W-1:0]      need_ff;
   logic [IDX_W-1:0]                cur_ff;
   logic [SZ_W-1:0]                 pos_ff;

   // selected block (fit pick, id hit, then free target)
   logic                            have_tgt_ff;
   logic [IDX_W-1:0]                tgt_idx_ff;
   logic [SZ_W-1:0]                 tgt_size_ff;
   logic [OWN_W-1:0]                tgt_owner_ff;
   logic [PAD_W-1:0]                tgt_pad_ff;
   logic [LNK_W-1:0]                tgt_next_ff;
   logic [LNK_W-1:0]                tgt_prev_ff;
   logic [SZ_W-1:0]                 tgt_pos_ff;
   // offset hit
   logic                            have_off_ff;
   logic                            off_free_ff;
   logic [IDX_W-1:0]                off_idx_ff;
   logic [SZ_W-1:0]                 off_size_ff;
   logic [OWN_W-1:0]                off_owner_ff;
   logic [PAD_W-1:0]                off_pad_ff;
   logic [LNK_W-1:0]                off_next_ff;
   logic [LNK_W-1:0]                off_prev_ff;
   logic [SZ_W-1:0]                 off_pos_ff;
   // neighbors and merge results
   logic                            n_free_ff;
   logic [SZ_W-1:0]                 n_size_ff;
   logic [LNK_W-1:0]                n_next_ff;
   logic                            p_free_ff;
   logic [SZ_W-1:0]                 p_size_ff;
   logic [OWN_W-1:0]                p_owner_ff;
   logic [PAD_W-1:0]                p_pad_ff;
   logic [SZ_W-1:0]                 c_size_ff;
   logic [LNK_W-1:0]                c_next_ff;
   logic                            split_ff;
   logic [IDX_W-1:0]                spare_ff;
   logic [OWN_W-1:0]                id_ff;
   // result
   fca_pkg::fca_status_type         status_ff;
   logic [fca_pkg::DOFF_W-1:0]      doff_ff;
   logic [fca_pkg::BID_W-1:0]       bid_ff;
   logic [fca_pkg::CNT_W-1:0]       req_cnt_ff;
   logic [fca_pkg::CNT_W-1:0]       ok_cnt_ff;
   logic                            rsp_valid_ff;
   logic [fca_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   fca_pkg::fca_status_type         rsp_status_ff;

   // table port
   logic                            tbl_rd_en;
   logic [IDX_W-1:0]                tbl_rd_addr;
   fca_pkg::fca_wmask_type          tbl_wr;
   logic [IDX_W-1:0]                tbl_wr_addr;
   logic [SZ_W-1:0]                 tbl_wr_size;
   logic                            tbl_wr_free;
   logic [OWN_W-1:0]                tbl_wr_owner;
   logic [PAD_W-1:0]                tbl_wr_pad;
   logic [LNK_W-1:0]                tbl_wr_next;
   logic [LNK_W-1:0]                tbl_wr_prev;
   logic [SZ_W-1:0]                 rd_size;
   logic                            rd_free;
   logic [OWN_W-1:0]                rd_owner;
   logic [PAD_W-1:0]                rd_pad;
   logic [LNK_W-1:0]                rd_next;
   logic [LNK_W-1:0]                rd_prev;

   // scan unit
   logic                            scan_start;
   logic                            scan_done;
   logic                            scan_spare_found;
   logic [IDX_W-1:0]                scan_spare_idx;
   logic [OWN_W-1:0]                scan_free_id;

   logic                            req_acc;
   logic                            rsp_load;
   logic                            walk_end;
   logic                            fit_cand;
   logic                            fit_take;
   logic                            id_take;
   logic                            off_take;
   logic                            is_alloc;
   logic [CW-1:0]                   here_off;
   logic [fca_pkg::NEED_W-1:0]      need_in;
   logic                            split_in;

   fca_table #(
      .ARENA_BYTES (ARENA_BYTES),
      .HEADER_BYTES(HEADER_BYTES),
      .MAX_BLOCKS  (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .wr_mask (tbl_wr),
      .wr_addr (tbl_wr_addr),
      .wr_size (tbl_wr_size),
      .wr_free (tbl_wr_free),
      .wr_owner(tbl_wr_owner),
      .wr_pad  (tbl_wr_pad),
      .wr_next (tbl_wr_next),
      .wr_prev (tbl_wr_prev),
      .rd_size (rd_size),
      .rd_free (rd_free),
      .rd_owner(rd_owner),
      .rd_pad  (rd_pad),
      .rd_next (rd_next),
      .rd_prev (rd_prev)
   );

   fca_scan #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (req_acc),
      .mark_en    (state_ff == S_WALK),
      .mark_idx   (cur_ff),
      .take_en    ((state_ff == S_WALK) && !rd_free),
      .take_id    (rd_owner),
      .start      (scan_start),
      .done       (scan_done),
      .spare_found(scan_spare_found),
      .spare_idx  (scan_spare_idx),
      .free_id    (scan_free_id)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign is_alloc   = (kind_ff == fca_pkg::REQ_ALLOC);
   assign need_in    = (fca_pkg::NEED_W'(req_tdata[fca_pkg::SIZE_IN_W-1:0]) +
                        fca_pkg::NEED_W'(7)) & ~fca_pkg::NEED_W'(7);

   // chain walk step
   assign here_off = CW'(pos_ff) + CW'(HEADER_BYTES);
   assign walk_end = (rd_next >= LNK_W'(MAX_BLOCKS));
   assign fit_cand = rd_free && (CW'(rd_size) >= CW'(need_ff));
   always_comb begin
      case (strat_ff)
         fca_pkg::FIT_BEST:  fit_take = fit_cand && (!have_tgt_ff || rd_size < tgt_size_ff);
         fca_pkg::FIT_WORST: fit_take = fit_cand && (!have_tgt_ff || rd_size > tgt_size_ff);
         default:            fit_take = fit_cand && !have_tgt_ff;
      endcase
   end
   assign id_take  = !have_tgt_ff && !rd_free && (val_ff != '0) &&
                     (CW'(rd_owner) == CW'(val_ff));
   assign off_take = !have_off_ff && (here_off == CW'(val_ff));
   assign split_in = scan_spare_found &&
                     (CW'(tgt_size_ff) >= CW'(need_ff) + CW'(HEADER_BYTES) + CW'(1));
   assign scan_start = (state_ff == S_POST) && is_alloc && have_tgt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_acc) state_in = S_WALK;
         S_WALK:   if (walk_end) state_in = S_POST;
         S_POST: begin
            if (is_alloc) begin
               state_in = have_tgt_ff ? S_SCAN : S_DONE;
            end else if (kind_ff == fca_pkg::REQ_FREE_OFF) begin
               state_in = (have_off_ff && !off_free_ff) ? S_F_RDN : S_DONE;
            end else if (have_tgt_ff) begin
               state_in = S_F_RDN;
            end else if (kind_ff == fca_pkg::REQ_FREE_ID_OFF &&
                         CW'(val_ff) < CW'(ARENA_BYTES) &&
                         have_off_ff && !off_free_ff) begin
               state_in = S_F_RDN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN:   if (scan_done) state_in = split_in ? S_A_WR_S : S_A_WR_C;
         S_A_WR_S: state_in = S_A_WR_C;
         S_A_WR_C: state_in = (split_ff && tgt_next_ff < LNK_W'(MAX_BLOCKS)) ?
                              S_A_WR_N : S_DONE;
         S_A_WR_N: state_in = S_DONE;
         S_F_RDN:  state_in = S_F_RDP;
         S_F_RDP:  state_in = S_F_GOTP;
         S_F_GOTP: state_in = S_F_WR_C;
         S_F_WR_C: state_in = S_F_WR_X;
         S_F_WR_X: state_in = p_free_ff ? S_F_WR_P : S_DONE;
         S_F_WR_P: state_in = S_DONE;
         S_DONE:   if (rsp_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // table port
   always_comb begin
      tbl_rd_en    = 1'b0;
      tbl_rd_addr  = '0;
      tbl_wr       = '0;
      tbl_wr_addr  = tgt_idx_ff;
      tbl_wr_size  = tgt_size_ff;
      tbl_wr_free  = 1'b1;
      tbl_wr_owner = '0;
      tbl_wr_pad   = tgt_pad_ff;
      tbl_wr_next  = tgt_next_ff;
      tbl_wr_prev  = LNK_W'(tgt_idx_ff);
      case (state_ff)
         S_IDLE: begin
            tbl_rd_en = req_acc;
         end
         S_WALK: begin
            tbl_rd_en   = !walk_end;
            tbl_rd_addr = rd_next[IDX_W-1:0];
         end
         S_A_WR_S: begin
            // new free remainder after the allocated part
            tbl_wr.main = 1'b1;
            tbl_wr.prev = 1'b1;
            tbl_wr_addr = spare_ff;
            tbl_wr_size = SZ_W'(CW'(tgt_size_ff) - CW'(need_ff) - CW'(HEADER_BYTES));
            tbl_wr_pad  = '0;
         end
         S_A_WR_C: begin
            tbl_wr.main  = 1'b1;
            tbl_wr_size  = split_ff ? SZ_W'(need_ff) : tgt_size_ff;
            tbl_wr_free  = 1'b0;
            tbl_wr_owner = id_ff;
            tbl_wr_pad   = PAD_W'(need_ff - fca_pkg::NEED_W'(size_ff));
            tbl_wr_next  = split_ff ? LNK_W'(spare_ff) : tgt_next_ff;
         end
         S_A_WR_N: begin
            tbl_wr.prev = 1'b1;
            tbl_wr_addr = tgt_next_ff[IDX_W-1:0];
            tbl_wr_prev = LNK_W'(spare_ff);
         end
         S_F_RDN: begin
            tbl_rd_en   = (tgt_next_ff < LNK_W'(MAX_BLOCKS));
            tbl_rd_addr = tgt_next_ff[IDX_W-1:0];
         end
         S_F_RDP: begin
            tbl_rd_en   = (tgt_prev_ff < LNK_W'(MAX_BLOCKS));
            tbl_rd_addr = tgt_prev_ff[IDX_W-1:0];
         end
         S_F_WR_C: begin
            // released block, absorbing a free next neighbor
            tbl_wr.main = 1'b1;
            tbl_wr_size = n_free_ff ?
                          SZ_W'(CW'(tgt_size_ff) + CW'(HEADER_BYTES) + CW'(n_size_ff)) :
                          tgt_size_ff;
            tbl_wr_next = n_free_ff ? n_next_ff : tgt_next_ff;
         end
         S_F_WR_X: begin
            // back link of the block that follows the merged run
            tbl_wr.prev = (n_free_ff || p_free_ff) && (c_next_ff < LNK_W'(MAX_BLOCKS));
            tbl_wr_addr = c_next_ff[IDX_W-1:0];
            tbl_wr_prev = p_free_ff ? tgt_prev_ff : LNK_W'(tgt_idx_ff);
         end
         S_F_WR_P: begin
            tbl_wr.main  = 1'b1;
            tbl_wr_addr  = tgt_prev_ff[IDX_W-1:0];
            tbl_wr_size  = SZ_W'(CW'(p_size_ff) + CW'(HEADER_BYTES) + CW'(c_size_ff));
            tbl_wr_owner = p_owner_ff;
            tbl_wr_pad   = p_pad_ff;
            tbl_wr_next  = c_next_ff;
         end
         default: begin
            tbl_rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         strat_ff     <= '0;
         req_cnt_ff   <= '0;
         ok_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         have_tgt_ff  <= 1'b0;
         have_off_ff  <= 1'b0;
         status_ff    <= fca_pkg::ST_OK;
         split_ff     <= 1'b0;
         id_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            strat_ff <= csr_wr_data;
         end

         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= status_ff;
            rsp_data_ff   <= {4'd0, ok_cnt_ff, req_cnt_ff, bid_ff, doff_ff};
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  kind_ff     <= fca_pkg::fca_kind_type'(req_tuser);
                  size_ff     <= req_tdata[fca_pkg::SIZE_IN_W-1:0];
                  val_ff      <= req_tdata[fca_pkg::REQ_DATA_W-1:fca_pkg::SIZE_IN_W];
                  need_ff     <= need_in;
                  cur_ff      <= '0;
                  pos_ff      <= '0;
                  have_tgt_ff <= 1'b0;
                  have_off_ff <= 1'b0;
                  split_ff    <= 1'b0;
                  status_ff   <= fca_pkg::ST_OK;
                  doff_ff     <= '0;
                  bid_ff      <= '0;
                  if (fca_pkg::fca_kind_type'(req_tuser) == fca_pkg::REQ_ALLOC &&
                      req_cnt_ff != '1) begin
                     req_cnt_ff <= req_cnt_ff + fca_pkg::CNT_W'(1);
                  end
               end
            end
            S_WALK: begin
               cur_ff <= rd_next[IDX_W-1:0];
               pos_ff <= SZ_W'(here_off + CW'(rd_size));
               if (is_alloc ? fit_take : id_take) begin
                  have_tgt_ff  <= 1'b1;
                  tgt_idx_ff   <= cur_ff;
                  tgt_size_ff  <= rd_size;
                  tgt_owner_ff <= rd_owner;
                  tgt_pad_ff   <= rd_pad;
                  tgt_next_ff  <= rd_next;
                  tgt_prev_ff  <= rd_prev;
                  tgt_pos_ff   <= pos_ff;
               end
               if (off_take) begin
                  have_off_ff  <= 1'b1;
                  off_free_ff  <= rd_free;
                  off_idx_ff   <= cur_ff;
                  off_size_ff  <= rd_size;
                  off_owner_ff <= rd_owner;
                  off_pad_ff   <= rd_pad;
                  off_next_ff  <= rd_next;
                  off_prev_ff  <= rd_prev;
                  off_pos_ff   <= pos_ff;
               end
            end
            S_POST: begin
               if (state_in == S_DONE) begin
                  if (is_alloc) begin
                     status_ff <= fca_pkg::ST_NO_FIT;
                  end else if (kind_ff == fca_pkg::REQ_FREE_OFF) begin
                     if (have_off_ff) begin
                        status_ff <= fca_pkg::ST_ALREADY_FREE;
                        doff_ff   <= fca_pkg::DOFF_W'(val_ff);
                     end else begin
                        status_ff <= fca_pkg::ST_BAD_ADDR;
                     end
                  end else begin
                     status_ff <= fca_pkg::ST_NO_ID;
                  end
               end else if (!is_alloc &&
                            (kind_ff == fca_pkg::REQ_FREE_OFF || !have_tgt_ff)) begin
                  // free target comes from the offset hit
                  tgt_idx_ff   <= off_idx_ff;
                  tgt_size_ff  <= off_size_ff;
                  tgt_owner_ff <= off_owner_ff;
                  tgt_pad_ff   <= off_pad_ff;
                  tgt_next_ff  <= off_next_ff;
                  tgt_prev_ff  <= off_prev_ff;
                  tgt_pos_ff   <= off_pos_ff;
               end
            end
            S_SCAN: begin
               if (scan_done) begin
                  split_ff <= split_in;
                  spare_ff <= scan_spare_idx;
                  id_ff    <= scan_free_id;
               end
            end
            S_A_WR_C: begin
               doff_ff <= fca_pkg::DOFF_W'(CW'(tgt_pos_ff) + CW'(HEADER_BYTES));
               bid_ff  <= fca_pkg::BID_W'(id_ff);
               if (ok_cnt_ff != '1) begin
                  ok_cnt_ff <= ok_cnt_ff + fca_pkg::CNT_W'(1);
               end
            end
            S_F_RDN: begin
               doff_ff <= fca_pkg::DOFF_W'(CW'(tgt_pos_ff) + CW'(HEADER_BYTES));
               bid_ff  <= fca_pkg::BID_W'(tgt_owner_ff);
            end
            S_F_RDP: begin
               n_free_ff <= (tgt_next_ff < LNK_W'(MAX_BLOCKS)) && rd_free;
               n_size_ff <= rd_size;
               n_next_ff <= rd_next;
            end
            S_F_GOTP: begin
               p_free_ff  <= (tgt_prev_ff < LNK_W'(MAX_BLOCKS)) && rd_free;
               p_size_ff  <= rd_size;
               p_owner_ff <= rd_owner;
               p_pad_ff   <= rd_pad;
            end
            S_F_WR_C: begin
               c_size_ff <= tbl_wr_size;
               c_next_ff <= tbl_wr_next;
            end
            default: begin
               cur_ff <= cur_ff;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_ok_le_req: assert property (@(posedge clock) disable iff (reset)
      ok_cnt_ff <= req_cnt_ff)
      else $error("success count above request count");

   a_wr_only_ok: assert property (@(posedge clock) disable iff (reset)
      (tbl_wr.main || tbl_wr.prev) |-> status_ff == fca_pkg::ST_OK)
      else $error("table write on a failed request");

   a_alloc_id: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && is_alloc && status_ff == fca_pkg::ST_OK) |-> id_ff != '0)
      else $error("allocation without id");

   a_split_wr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_WR_S) |-> (split_ff && have_tgt_ff))
      else $error("remainder write without split");

endmodule

>>> rtl/fca_table.sv
`timescale 1ns / 1ps

module fca_table #(
   parameter int ARENA_BYTES  = fca_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = fca_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = fca_pkg::MAX_BLOCKS_DEF,
   localparam int IDX_W = $clog2(MAX_BLOCKS),
   localparam int LNK_W = $clog2(MAX_BLOCKS + 1),
   localparam int SZ_W  = $clog2(ARENA_BYTES) + 1,
   localparam int OWN_W = $clog2(MAX_BLOCKS + 2)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   input  fca_pkg::fca_wmask_type   wr_mask,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [SZ_W-1:0]          wr_size,
   input  logic                     wr_free,
   input  logic [OWN_W-1:0]         wr_owner,
   input  logic [fca_pkg::PAD_W-1:0] wr_pad,
   input  logic [LNK_W-1:0]         wr_next,
   input  logic [LNK_W-1:0]         wr_prev,
   output logic [SZ_W-1:0]          rd_size,
   output logic                     rd_free,
   output logic [OWN_W-1:0]         rd_owner,
   output logic [fca_pkg::PAD_W-1:0] rd_pad,
   output logic [LNK_W-1:0]         rd_next,
   output logic [LNK_W-1:0]         rd_prev
);

   localparam int MW = SZ_W + 1 + OWN_W + fca_pkg::PAD_W + LNK_W;

   logic [MW-1:0]    main_mem [MAX_BLOCKS];
   logic [LNK_W-1:0] prev_mem [MAX_BLOCKS];
   logic [MW-1:0]    rd_word_ff;
   logic [LNK_W-1:0] rd_prev_ff;
   logic             main0_ok_ff;
   logic             prev0_ok_ff;
   logic             use0_main_ff;
   logic             use0_prev_ff;
   logic [MW-1:0]    wr_word;

   assign wr_word = {wr_size, wr_free, wr_owner, wr_pad, wr_next};

   always_ff @(posedge clock) begin
      if (wr_mask.main) begin
         main_mem[wr_addr] <= wr_word;
      end
      if (wr_mask.prev) begin
         prev_mem[wr_addr] <= wr_prev;
      end
      if (rd_en) begin
         rd_word_ff <= main_mem[rd_addr];
         rd_prev_ff <= prev_mem[rd_addr];
      end
   end

   // Head entry reads as its reset record until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         main0_ok_ff  <= 1'b0;
         prev0_ok_ff  <= 1'b0;
         use0_main_ff <= 1'b0;
         use0_prev_ff <= 1'b0;
      end else begin
         if (wr_mask.main && wr_addr == '0) begin
            main0_ok_ff <= 1'b1;
         end
         if (wr_mask.prev && wr_addr == '0) begin
            prev0_ok_ff <= 1'b1;
         end
         if (rd_en) begin
            use0_main_ff <= (rd_addr == '0) && !main0_ok_ff;
            use0_prev_ff <= (rd_addr == '0) && !prev0_ok_ff;
         end
      end
   end

   always_comb begin
      if (use0_main_ff) begin
         rd_size  = SZ_W'(ARENA_BYTES - HEADER_BYTES);
         rd_free  = 1'b1;
         rd_owner = '0;
         rd_pad   = '0;
         rd_next  = LNK_W'(MAX_BLOCKS);
      end else begin
         {rd_size, rd_free, rd_owner, rd_pad, rd_next} = rd_word_ff;
      end
      rd_prev = use0_prev_ff ? LNK_W'(MAX_BLOCKS) : rd_prev_ff;
   end

endmodule

>>> rtl/fca_scan.sv
`timescale 1ns / 1ps

module fca_scan #(
   parameter int MAX_BLOCKS = fca_pkg::MAX_BLOCKS_DEF,
   localparam int IDX_W = $clog2(MAX_BLOCKS),
   localparam int OWN_W = $clog2(MAX_BLOCKS + 2)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             mark_en,
   input  logic [IDX_W-1:0] mark_idx,
   input  logic             take_en,
   input  logic [OWN_W-1:0] take_id,
   input  logic             start,
   output logic             done,
   output logic             spare_found,
   output logic [IDX_W-1:0] spare_idx,
   output logic [OWN_W-1:0] free_id
);

   logic [MAX_BLOCKS-1:0] used_ff;    // entry is on the chain
   logic [MAX_BLOCKS-1:0] taken_ff;   // bit i: id i+1 held
   logic [IDX_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic                  spf_ff;
   logic                  idf_ff;
   logic [IDX_W-1:0]      spare_ff;
   logic [OWN_W-1:0]      id_ff;
   logic                  take_ok;

   assign take_ok = take_en && (take_id != '0) &&
                    ({1'b0, take_id} <= (OWN_W + 1)'(MAX_BLOCKS));

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         taken_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         spf_ff   <= 1'b0;
         idf_ff   <= 1'b0;
      end else begin
         if (clear) begin
            used_ff  <= '0;
            taken_ff <= '0;
         end else begin
            if (mark_en) begin
               used_ff[mark_idx] <= 1'b1;
            end
            if (take_ok) begin
               taken_ff[IDX_W'(take_id - OWN_W'(1))] <= 1'b1;
            end
         end
         if (start) begin
            busy_ff  <= 1'b1;
            done_ff  <= 1'b0;
            cnt_ff   <= '0;
            spf_ff   <= 1'b0;
            idf_ff   <= 1'b0;
            id_ff    <= OWN_W'(MAX_BLOCKS + 1);
         end else if (busy_ff) begin
            if (!spf_ff && !used_ff[cnt_ff]) begin
               spf_ff   <= 1'b1;
               spare_ff <= cnt_ff;
            end
            if (!idf_ff && !taken_ff[cnt_ff]) begin
               idf_ff <= 1'b1;
               id_ff  <= OWN_W'(cnt_ff) + OWN_W'(1);
            end
            if (cnt_ff == IDX_W'(MAX_BLOCKS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + IDX_W'(1);
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign done        = done_ff;
   assign spare_found = spf_ff;
   assign spare_idx   = spare_ff;
   assign free_id     = id_ff;

endmodule
